// File: sv/gei_pkg.sv
// Shared widths, register indexes, axis codes and the face lookup for the
// grid edge incidence generator. No dependencies; every other file imports it.
package gei_pkg;

  // Field widths
  localparam int COORD_W   = 6;
  localparam int AXIS_W    = 2;
  localparam int DIM_W     = 7;
  localparam int EDGE_W    = 20;
  localparam int POINT_W   = 19;
  localparam int FACE_W    = 21;
  localparam int SIGN_W    = 2;
  localparam int CFG_IDX_W = 2;

  // Derived widths: dx*dy, 3*dx, 3*dx*dy and the working linear index
  localparam int DXY_W  = 2 * DIM_W;
  localparam int DX3_W  = DIM_W + 2;
  localparam int DXY3_W = DXY_W + 2;
  localparam int LIN_W  = FACE_W;

  localparam int NUM_FACES = 4;
  localparam int SLOT_W    = 2;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DIM_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DIM_Z = 2'd2;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  // Axis codes; the remaining code names no axis
  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  localparam logic signed [SIGN_W-1:0] SIGN_POS  = 2'sb01;
  localparam logic signed [SIGN_W-1:0] SIGN_NEG  = 2'sb11;
  localparam logic signed [SIGN_W-1:0] SIGN_ZERO = 2'sb00;

  // Which point a face hangs off, relative to the edge start point
  typedef enum logic [1:0] {
    NBR_SELF,
    NBR_XM,
    NBR_YM,
    NBR_ZM
  } nbr_t;

  typedef struct packed {
    nbr_t                     nbr;
    logic [AXIS_W-1:0]        faxis;
    logic signed [SIGN_W-1:0] sign;
  } face_ent_t;

  // Live grid sizes plus products derived from them
  typedef struct packed {
    logic [DIM_W-1:0]  dx;
    logic [DIM_W-1:0]  dy;
    logic [DIM_W-1:0]  dz;
    logic [DXY_W-1:0]  dxy;
    logic [DX3_W-1:0]  dx3;
    logic [DXY3_W-1:0] dxy3;
  } dims_t;

  function automatic face_ent_t mk_ent(input nbr_t nbr, input logic [AXIS_W-1:0] faxis,
                                       input logic signed [SIGN_W-1:0] sign);
    face_ent_t e;
    e.nbr   = nbr;
    e.faxis = faxis;
    e.sign  = sign;
    return e;
  endfunction

  // Face table: neighbour point, face axis and incidence sign per slot
  function automatic face_ent_t face_entry(input logic [AXIS_W-1:0] axis,
                                           input logic [SLOT_W-1:0] slot);
    face_ent_t e;
    e = mk_ent(NBR_SELF, AXIS_X, SIGN_ZERO);
    unique case (axis)
      AXIS_X: begin
        case (slot)
          2'd0:    e = mk_ent(NBR_SELF, AXIS_Z, SIGN_POS);
          2'd1:    e = mk_ent(NBR_YM,   AXIS_Z, SIGN_NEG);
          2'd2:    e = mk_ent(NBR_ZM,   AXIS_Y, SIGN_POS);
          default: e = mk_ent(NBR_SELF, AXIS_Y, SIGN_NEG);
        endcase
      end
      AXIS_Y: begin
        case (slot)
          2'd0:    e = mk_ent(NBR_XM,   AXIS_X, SIGN_POS);
          2'd1:    e = mk_ent(NBR_SELF, AXIS_X, SIGN_NEG);
          2'd2:    e = mk_ent(NBR_SELF, AXIS_Z, SIGN_POS);
          default: e = mk_ent(NBR_ZM,   AXIS_Z, SIGN_NEG);
        endcase
      end
      AXIS_Z: begin
        case (slot)
          2'd0:    e = mk_ent(NBR_XM,   AXIS_Y, SIGN_NEG);
          2'd1:    e = mk_ent(NBR_SELF, AXIS_Y, SIGN_POS);
          2'd2:    e = mk_ent(NBR_SELF, AXIS_X, SIGN_NEG);
          default: e = mk_ent(NBR_YM,   AXIS_X, SIGN_POS);
        endcase
      end
      default: e = mk_ent(NBR_SELF, AXIS_X, SIGN_ZERO);
    endcase
    return e;
  endfunction

endpackage

// File: sv/gei_if.sv
// Valid/ready channel interfaces for edge requests and incidence results.
// Depends on gei_pkg for field widths.
interface gei_in_if;
  import gei_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;
  logic [COORD_W-1:0] coord_z;
  logic [AXIS_W-1:0]  edge_axis;

  modport source (output valid, coord_x, coord_y, coord_z, edge_axis, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, edge_axis, output ready);
endinterface

interface gei_out_if;
  import gei_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      edge_valid;
  logic [EDGE_W-1:0]         edge_number;
  logic signed [POINT_W-1:0] start_point;
  logic signed [POINT_W-1:0] end_point;
  logic signed [FACE_W-1:0]  face_a;
  logic signed [FACE_W-1:0]  face_b;
  logic signed [FACE_W-1:0]  face_c;
  logic signed [FACE_W-1:0]  face_d;
  logic signed [SIGN_W-1:0]  sign_a;
  logic signed [SIGN_W-1:0]  sign_b;
  logic signed [SIGN_W-1:0]  sign_c;
  logic signed [SIGN_W-1:0]  sign_d;

  modport source (output valid, edge_valid, edge_number, start_point, end_point,
                  face_a, face_b, face_c, face_d, sign_a, sign_b, sign_c, sign_d,
                  input ready);
  modport sink   (input valid, edge_valid, edge_number, start_point, end_point,
                  face_a, face_b, face_c, face_d, sign_a, sign_b, sign_c, sign_d,
                  output ready);
endinterface

// File: sv/gei_cfg.sv
// Grid size registers with saturation on write, plus the size products the
// index pipeline needs. Depends on gei_pkg.
module gei_cfg #(
  parameter int MAX_DIM = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [gei_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gei_pkg::DIM_W-1:0]      cfg_data,
  output gei_pkg::dims_t                 dims
);
  import gei_pkg::*;

  logic [DIM_W-1:0] wval;

  // Clamp written sizes at the grid limit
  assign wval = (int'(cfg_data) > MAX_DIM) ? DIM_W'(MAX_DIM) : cfg_data;

  // Size registers; the derived products are registered from them, dxy3 from the registered dxy
  always_ff @(posedge clk) begin
    if (rst) begin
      dims.dx <= DIM_RESET;
      dims.dy <= DIM_RESET;
      dims.dz <= DIM_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DIM_X: dims.dx <= wval;
        REG_DIM_Y: dims.dy <= wval;
        REG_DIM_Z: dims.dz <= wval;
        default: ;
      endcase
    end
    dims.dxy  <= dims.dx * dims.dy;
    dims.dx3  <= DX3_W'({dims.dx, 1'b0}) + DX3_W'(dims.dx);
    dims.dxy3 <= DXY3_W'({dims.dxy, 1'b0}) + DXY3_W'(dims.dxy);
  end

endmodule

// File: sv/gei_pipe.sv
// Five-register index pipeline: capture, multiply and range checks, sum,
// triple and end point, face offsets into the output register. Depends on
// gei_pkg and gei_if.
module gei_pipe (
  input  logic           clk,
  input  logic           rst,
  input  gei_pkg::dims_t dims,
  gei_in_if.sink         in_ch,
  gei_out_if.source      out_ch
);
  import gei_pkg::*;

  localparam int ZP_W = COORD_W + DXY_W;
  localparam int YP_W = COORD_W + DIM_W;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [AXIS_W-1:0]  axis;
  } s1_t;

  typedef struct packed {
    logic [COORD_W-1:0]   x;
    logic [AXIS_W-1:0]    axis;
    logic [ZP_W-1:0]      zp;
    logic [YP_W-1:0]      yp;
    logic                 start_in;
    logic                 ev;
    logic [NUM_FACES-1:0] present;
  } s2_t;

  typedef struct packed {
    logic [AXIS_W-1:0]    axis;
    logic [LIN_W-1:0]     lin;
    logic                 start_in;
    logic                 ev;
    logic [NUM_FACES-1:0] present;
  } s3_t;

  typedef struct packed {
    logic [AXIS_W-1:0]    axis;
    logic [LIN_W-1:0]     lin;
    logic [LIN_W-1:0]     lin3;
    logic [POINT_W-1:0]   endp;
    logic                 start_in;
    logic                 ev;
    logic [NUM_FACES-1:0] present;
  } s4_t;

  logic v1, v2, v3, v4;
  logic r1, r2, r3, r4, r_out;
  s1_t  s1;
  s2_t  s2, s2_next;
  s3_t  s3, s3_next;
  s4_t  s4, s4_next;

  logic [FACE_W-1:0]        face_next [NUM_FACES];
  logic signed [SIGN_W-1:0] sign_next [NUM_FACES];
  logic [EDGE_W-1:0]        edge_number_next;
  logic [POINT_W-1:0]       start_next;
  logic [POINT_W-1:0]       end_next;

  // Per-stage ready: a stage moves when it is empty or its successor moves
  assign r_out       = !out_ch.valid || out_ch.ready;
  assign r4          = !v4 || r_out;
  assign r3          = !v3 || r4;
  assign r2          = !v2 || r3;
  assign r1          = !v1 || r2;
  assign in_ch.ready = r1;

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      out_ch.valid <= 1'b0;
    end else begin
      if (r1)    v1           <= in_ch.valid;
      if (r2)    v2           <= v1;
      if (r3)    v3           <= v2;
      if (r4)    v4           <= v3;
      if (r_out) out_ch.valid <= v4;
    end
  end

  // Stage 1: capture the request
  always_ff @(posedge clk) begin
    if (r1 && in_ch.valid) begin
      s1.x    <= in_ch.coord_x;
      s1.y    <= in_ch.coord_y;
      s1.z    <= in_ch.coord_z;
      s1.axis <= in_ch.edge_axis;
    end
  end

  // Stage 2: partial products, grid bounds and face presence
  always_comb begin
    logic [DIM_W-1:0] xe, ye, ze, nx, ny, nz;
    logic             x_in, y_in, z_in, nbr_ok, dang;
    face_ent_t        ent;

    xe   = DIM_W'(s1.x);
    ye   = DIM_W'(s1.y);
    ze   = DIM_W'(s1.z);
    x_in = xe < dims.dx;
    y_in = ye < dims.dy;
    z_in = ze < dims.dz;

    s2_next.x        = s1.x;
    s2_next.axis     = s1.axis;
    s2_next.zp       = ZP_W'(s1.z) * ZP_W'(dims.dxy);
    s2_next.yp       = YP_W'(s1.y) * YP_W'(dims.dx);
    s2_next.start_in = x_in && y_in && z_in;

    // End point inside the grid
    case (s1.axis)
      AXIS_X:  s2_next.ev = ((xe + DIM_W'(1)) < dims.dx) && y_in && z_in;
      AXIS_Y:  s2_next.ev = x_in && ((ye + DIM_W'(1)) < dims.dy) && z_in;
      AXIS_Z:  s2_next.ev = x_in && y_in && ((ze + DIM_W'(1)) < dims.dz);
      default: s2_next.ev = 1'b0;
    endcase

    // A face is present if the edge is valid, its point exists and it does not dangle
    for (int k = 0; k < NUM_FACES; k++) begin
      ent    = face_entry(s1.axis, SLOT_W'(k));
      nx     = (ent.nbr == NBR_XM) ? xe - DIM_W'(1) : xe;
      ny     = (ent.nbr == NBR_YM) ? ye - DIM_W'(1) : ye;
      nz     = (ent.nbr == NBR_ZM) ? ze - DIM_W'(1) : ze;
      nbr_ok = !((ent.nbr == NBR_XM) && (s1.x == '0)) &&
               !((ent.nbr == NBR_YM) && (s1.y == '0)) &&
               !((ent.nbr == NBR_ZM) && (s1.z == '0));
      case (ent.faxis)
        AXIS_X:  dang = nx == (dims.dx - DIM_W'(1));
        AXIS_Y:  dang = ny == (dims.dy - DIM_W'(1));
        default: dang = nz == (dims.dz - DIM_W'(1));
      endcase
      s2_next.present[k] = s2_next.ev && nbr_ok && !dang;
    end
  end

  always_ff @(posedge clk) begin
    if (r2 && v1) s2 <= s2_next;
  end

  // Stage 3: start point linear index
  always_comb begin
    s3_next.axis     = s2.axis;
    s3_next.lin      = LIN_W'(s2.zp) + LIN_W'(s2.yp) + LIN_W'(s2.x);
    s3_next.start_in = s2.start_in;
    s3_next.ev       = s2.ev;
    s3_next.present  = s2.present;
  end

  always_ff @(posedge clk) begin
    if (r3 && v2) s3 <= s3_next;
  end

  // Stage 4: three times the index, and the end point
  always_comb begin
    logic [LIN_W-1:0] step, lin_end;

    case (s3.axis)
      AXIS_X:  step = LIN_W'(1);
      AXIS_Y:  step = LIN_W'(dims.dx);
      AXIS_Z:  step = LIN_W'(dims.dxy);
      default: step = '0;
    endcase
    lin_end = s3.lin + step;

    s4_next.axis     = s3.axis;
    s4_next.lin      = s3.lin;
    s4_next.lin3     = {s3.lin[LIN_W-2:0], 1'b0} + s3.lin;
    s4_next.endp     = lin_end[POINT_W-1:0];
    s4_next.start_in = s3.start_in;
    s4_next.ev       = s3.ev;
    s4_next.present  = s3.present;
  end

  always_ff @(posedge clk) begin
    if (r4 && v3) s4 <= s4_next;
  end

  // Stage 5: edge number and face indices from the tripled index
  always_comb begin
    logic [LIN_W-1:0] off3;
    face_ent_t        ent;

    edge_number_next = s4.lin3[EDGE_W-1:0] + EDGE_W'(s4.axis);
    start_next       = s4.start_in ? s4.lin[POINT_W-1:0] : '1;
    end_next         = s4.ev ? s4.endp : '1;

    for (int k = 0; k < NUM_FACES; k++) begin
      ent = face_entry(s4.axis, SLOT_W'(k));
      case (ent.nbr)
        NBR_SELF: off3 = '0;
        NBR_XM:   off3 = LIN_W'(3);
        NBR_YM:   off3 = LIN_W'(dims.dx3);
        default:  off3 = LIN_W'(dims.dxy3);
      endcase
      face_next[k] = s4.present[k] ? (s4.lin3 - off3 + LIN_W'(ent.faxis)) : '1;
      sign_next[k] = s4.ev ? ent.sign : SIGN_ZERO;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (r_out && v4) begin
      out_ch.edge_valid  <= s4.ev;
      out_ch.edge_number <= edge_number_next;
      out_ch.start_point <= $signed(start_next);
      out_ch.end_point   <= $signed(end_next);
      out_ch.face_a      <= $signed(face_next[0]);
      out_ch.face_b      <= $signed(face_next[1]);
      out_ch.face_c      <= $signed(face_next[2]);
      out_ch.face_d      <= $signed(face_next[3]);
      out_ch.sign_a      <= sign_next[0];
      out_ch.sign_b      <= sign_next[1];
      out_ch.sign_c      <= sign_next[2];
      out_ch.sign_d      <= sign_next[3];
    end
  end

endmodule

// File: sv/grid_edge_incidence_generator_top.sv
// Grid edge incidence generator: takes one edge per cycle and returns its
// index, end points and four incident faces with signs. The work runs through
// five pipeline registers, and one edge is taken every cycle while the
// result side keeps up; a stall on the result side backs up stage by stage
// without loss. The grid sizes are written through the configuration port
// (values above MAX_DIM are held at MAX_DIM) and apply to edges sent from
// the cycle after the write. Depends on gei_pkg, gei_if, gei_cfg and gei_pipe.
module grid_edge_incidence_generator_top #(
  parameter int MAX_DIM = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [gei_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gei_pkg::DIM_W-1:0]     cfg_data,
  gei_in_if.sink                        edge_in,
  gei_out_if.source                     incidence_out
);
  import gei_pkg::*;

  dims_t dims;

  gei_cfg #(
    .MAX_DIM (MAX_DIM)
  ) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .dims      (dims)
  );

  gei_pipe u_pipe (
    .clk    (clk),
    .rst    (rst),
    .dims   (dims),
    .in_ch  (edge_in),
    .out_ch (incidence_out)
  );

endmodule

// File: sv/gei_checker.sv
// Port-level checks on the result channel of the incidence generator, and the
// bind that attaches them to the top level. Depends on gei_pkg.
module gei_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 valid,
  input logic                                 ready,
  input logic                                 edge_valid,
  input logic [gei_pkg::EDGE_W-1:0]           edge_number,
  input logic signed [gei_pkg::POINT_W-1:0]   start_point,
  input logic signed [gei_pkg::POINT_W-1:0]   end_point,
  input logic signed [gei_pkg::FACE_W-1:0]    face_a,
  input logic signed [gei_pkg::FACE_W-1:0]    face_b,
  input logic signed [gei_pkg::FACE_W-1:0]    face_c,
  input logic signed [gei_pkg::FACE_W-1:0]    face_d,
  input logic signed [gei_pkg::SIGN_W-1:0]    sign_a,
  input logic signed [gei_pkg::SIGN_W-1:0]    sign_b,
  input logic signed [gei_pkg::SIGN_W-1:0]    sign_c,
  input logic signed [gei_pkg::SIGN_W-1:0]    sign_d
);
  import gei_pkg::*;

  // Nothing leaves the pipeline straight after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !valid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    valid && !ready |=> valid && $stable(edge_number) && $stable(face_a) &&
                        $stable(end_point))
    else $error("stalled result changed");

  // Edge outside the grid: no end point, no faces, no signs
  a_invalid: assert property (@(posedge clk) disable iff (rst)
    valid && !edge_valid |-> end_point == '1 && face_a == '1 && face_b == '1 &&
                             face_c == '1 && face_d == '1 && sign_a == SIGN_ZERO &&
                             sign_b == SIGN_ZERO && sign_c == SIGN_ZERO &&
                             sign_d == SIGN_ZERO)
    else $error("invalid edge with faces or signs");

  // Signs of a valid edge alternate around its faces
  a_signs: assert property (@(posedge clk) disable iff (rst)
    valid && edge_valid |-> sign_a != SIGN_ZERO && sign_b == -sign_a &&
                            sign_c == sign_a && sign_d == sign_b)
    else $error("incidence signs do not alternate");

  // A valid edge has two distinct end points
  a_points: assert property (@(posedge clk) disable iff (rst)
    valid && edge_valid |-> !start_point[POINT_W-1] && !end_point[POINT_W-1] &&
                            end_point != start_point)
    else $error("valid edge with missing end point");

endmodule

bind grid_edge_incidence_generator_top gei_checker u_gei_checker (
  .clk         (clk),
  .rst         (rst),
  .valid       (incidence_out.valid),
  .ready       (incidence_out.ready),
  .edge_valid  (incidence_out.edge_valid),
  .edge_number (incidence_out.edge_number),
  .start_point (incidence_out.start_point),
  .end_point   (incidence_out.end_point),
  .face_a      (incidence_out.face_a),
  .face_b      (incidence_out.face_b),
  .face_c      (incidence_out.face_c),
  .face_d      (incidence_out.face_d),
  .sign_a      (incidence_out.sign_a),
  .sign_b      (incidence_out.sign_b),
  .sign_c      (incidence_out.sign_c),
  .sign_d      (incidence_out.sign_d)
);

// File: sim/grid_edge_incidence_checker.sv
// Scoreboard for the grid edge incidence generator: mirrors the grid sizes,
// predicts each incidence row from the edge transfers and compares the results.
// Depends on gei_pkg and the channel interfaces in gei_if.
module grid_edge_incidence_checker #(
  parameter int MAX_DIM = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [gei_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gei_pkg::DIM_W-1:0]     cfg_data,
  gei_in_if                    edge_in,
  gei_out_if                   incidence_out,
  output int                   mismatches,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import gei_pkg::*;

  // Edges and faces per grid point
  localparam int AXES_PER_POINT = 3;

  typedef struct packed {
    logic                             edge_valid;
    logic [EDGE_W-1:0]                edge_number;
    logic [POINT_W-1:0]               start_point;
    logic [POINT_W-1:0]               end_point;
    logic [NUM_FACES-1:0][FACE_W-1:0] face;
    logic [NUM_FACES-1:0][SIGN_W-1:0] sign;
  } incidence_t;

  // Grid sizes as the block should see them
  int grid_x;
  int grid_y;
  int grid_z;

  incidence_t incidence_q[$];

  function automatic bit on_grid(input longint x, input longint y, input longint z);
    return x >= 0 && y >= 0 && z >= 0 && x < grid_x && y < grid_y && z < grid_z;
  endfunction

  function automatic longint grid_lin(input longint x, input longint y, input longint z);
    return z * grid_y * grid_x + y * grid_x + x;
  endfunction

  function automatic longint point_index(input longint x, input longint y, input longint z);
    return on_grid(x, y, z) ? grid_lin(x, y, z) : -1;
  endfunction

  // Face hanging off point (x,y,z) along face axis fa; -1 when off grid or dangling
  function automatic longint grid_face(input longint x, input longint y, input longint z,
                                       input logic [AXIS_W-1:0] fa);
    if (!on_grid(x, y, z))
      return -1;
    if ((fa == AXIS_X && x == grid_x - 1) || (fa == AXIS_Y && y == grid_y - 1) ||
        (fa == AXIS_Z && z == grid_z - 1))
      return -1;
    return AXES_PER_POINT * grid_lin(x, y, z) + fa;
  endfunction

  function automatic incidence_t predict_incidence(input logic [COORD_W-1:0] cx,
                                                   input logic [COORD_W-1:0] cy,
                                                   input logic [COORD_W-1:0] cz,
                                                   input logic [AXIS_W-1:0]  ax);
    incidence_t r;
    longint     x;
    longint     y;
    longint     z;
    longint     far_pt;
    x = cx;
    y = cy;
    z = cz;
    r = '0;
    r.edge_number = EDGE_W'(AXES_PER_POINT * grid_lin(x, y, z) + ax);
    r.start_point = POINT_W'(point_index(x, y, z));
    case (ax)
      AXIS_X:  far_pt = point_index(x + 1, y, z);
      AXIS_Y:  far_pt = point_index(x, y + 1, z);
      AXIS_Z:  far_pt = point_index(x, y, z + 1);
      default: far_pt = -1;
    endcase
    r.end_point  = POINT_W'(far_pt);
    r.edge_valid = far_pt >= 0;
    // invalid edge: all faces absent, all signs zero
    for (int n = 0; n < NUM_FACES; n++) begin
      r.face[n] = '1;
      r.sign[n] = SIGN_ZERO;
    end
    if (r.edge_valid) begin
      case (ax)
        AXIS_X: begin
          r.face[0] = FACE_W'(grid_face(x, y, z, AXIS_Z));     r.sign[0] = SIGN_POS;
          r.face[1] = FACE_W'(grid_face(x, y - 1, z, AXIS_Z)); r.sign[1] = SIGN_NEG;
          r.face[2] = FACE_W'(grid_face(x, y, z - 1, AXIS_Y)); r.sign[2] = SIGN_POS;
          r.face[3] = FACE_W'(grid_face(x, y, z, AXIS_Y));     r.sign[3] = SIGN_NEG;
        end
        AXIS_Y: begin
          r.face[0] = FACE_W'(grid_face(x - 1, y, z, AXIS_X)); r.sign[0] = SIGN_POS;
          r.face[1] = FACE_W'(grid_face(x, y, z, AXIS_X));     r.sign[1] = SIGN_NEG;
          r.face[2] = FACE_W'(grid_face(x, y, z, AXIS_Z));     r.sign[2] = SIGN_POS;
          r.face[3] = FACE_W'(grid_face(x, y, z - 1, AXIS_Z)); r.sign[3] = SIGN_NEG;
        end
        default: begin
          r.face[0] = FACE_W'(grid_face(x - 1, y, z, AXIS_Y)); r.sign[0] = SIGN_NEG;
          r.face[1] = FACE_W'(grid_face(x, y, z, AXIS_Y));     r.sign[1] = SIGN_POS;
          r.face[2] = FACE_W'(grid_face(x, y, z, AXIS_X));     r.sign[2] = SIGN_NEG;
          r.face[3] = FACE_W'(grid_face(x, y - 1, z, AXIS_X)); r.sign[3] = SIGN_POS;
        end
      endcase
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic signed [31:0] want,
                             input logic signed [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Watch both channels and the register port at every edge
  always @(posedge clk) begin
    incidence_t got;
    incidence_t want;
    int         dim_val;
    if (rst) begin
      incidence_q.delete();
      grid_x     = DIM_RESET;
      grid_y     = DIM_RESET;
      grid_z     = DIM_RESET;
      mismatches = 0;
      pending   <= 0;
    end else begin
      // result transfer: compare with the oldest prediction
      if (incidence_out.valid && incidence_out.ready) begin
        got.edge_valid  = incidence_out.edge_valid;
        got.edge_number = incidence_out.edge_number;
        got.start_point = incidence_out.start_point;
        got.end_point   = incidence_out.end_point;
        got.face        = {incidence_out.face_d, incidence_out.face_c,
                           incidence_out.face_b, incidence_out.face_a};
        got.sign        = {incidence_out.sign_d, incidence_out.sign_c,
                           incidence_out.sign_b, incidence_out.sign_a};
        if (incidence_q.size() == 0) begin
          $display("%0t: result transfer with no edge outstanding, expected none, got edge %0d",
                   $time, got.edge_number);
          mismatches++;
        end else begin
          want = incidence_q.pop_front();
          check_field("edge_valid", want.edge_valid, got.edge_valid);
          check_field("edge_number", want.edge_number, got.edge_number);
          check_field("start_point", $signed(want.start_point), $signed(got.start_point));
          check_field("end_point", $signed(want.end_point), $signed(got.end_point));
          for (int n = 0; n < NUM_FACES; n++) begin
            check_field($sformatf("face_%c", 8'h61 + n), $signed(want.face[n]),
                        $signed(got.face[n]));
            check_field($sformatf("sign_%c", 8'h61 + n), $signed(want.sign[n]),
                        $signed(got.sign[n]));
          end
        end
      end
      // edge transfer uses the sizes in force before any write at this edge
      if (edge_in.valid && edge_in.ready)
        incidence_q.push_back(predict_incidence(edge_in.coord_x, edge_in.coord_y,
                                                edge_in.coord_z, edge_in.edge_axis));
      if (cfg_write) begin
        dim_val = cfg_data;
        if (dim_val > MAX_DIM)
          dim_val = MAX_DIM;
        case (cfg_index)
          REG_DIM_X: grid_x = dim_val;
          REG_DIM_Y: grid_y = dim_val;
          REG_DIM_Z: grid_z = dim_val;
          default: ;
        endcase
      end
      pending <= incidence_q.size();
    end
  end

endmodule

// File: sim/grid_edge_incidence_generator_top_tb.sv
// Testbench top for the grid edge incidence generator: clock, reset, grid size
// writes, edge stimulus and result back-pressure, plus the final verdict.
// Depends on gei_pkg, gei_if, the block and grid_edge_incidence_checker.
module grid_edge_incidence_generator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import gei_pkg::*;

  localparam int MAX_DIM      = 64;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int NUM_PHASES   = 10;
  localparam int PHASE_EDGES  = 100;
  // the one axis code that names no axis
  localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd3;

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DIM_W-1:0]     cfg_data;
  logic                 sink_ready = 1'b0;

  int mismatches;
  int pending;
  int cycle_count = 0;
  int stall_left  = 0;
  bit steady      = 1'b0;
  // grid sizes after saturation, used to aim the coordinates
  int span_x = MAX_DIM;
  int span_y = MAX_DIM;
  int span_z = MAX_DIM;

  gei_in_if  edge_in ();
  gei_out_if incidence_out ();

  assign incidence_out.ready = sink_ready;

  grid_edge_incidence_generator_top #(.MAX_DIM(MAX_DIM)) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .edge_in      (edge_in),
    .incidence_out(incidence_out)
  );

  grid_edge_incidence_checker #(.MAX_DIM(MAX_DIM)) checker_i (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .edge_in      (edge_in),
    .incidence_out(incidence_out),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // Mostly no gap, some short, a few long; none in steady phases
  function automatic int pick_gap();
    int r;
    if (steady)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 55)
      return 0;
    if (r < 90)
      return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Result side back-pressure
  always @(posedge clk) begin
    if (rst) begin
      sink_ready <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      sink_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      sink_ready <= 1'b1;
      stall_left <= pick_gap();
    end
  end

  // Mostly on the grid, some on its border, some anywhere
  function automatic logic [COORD_W-1:0] pick_coord(input int span);
    int r;
    r = $urandom_range(0, 99);
    if (span == 0 || r >= 85)
      return COORD_W'($urandom_range(0, 63));
    if (r < 70)
      return COORD_W'($urandom_range(0, span - 1));
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return COORD_W'(span - 1);
      default: return COORD_W'(span);
    endcase
  endfunction

  function automatic int pick_dim();
    return ($urandom_range(0, 99) < 80) ? $urandom_range(2, 64) : $urandom_range(0, 127);
  endfunction

  // One edge transfer; valid stays high into the next edge when there is no gap
  task automatic send_edge(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                           input logic [COORD_W-1:0] z, input logic [AXIS_W-1:0] ax);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      edge_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    edge_in.valid     <= 1'b1;
    edge_in.coord_x   <= x;
    edge_in.coord_y   <= y;
    edge_in.coord_z   <= z;
    edge_in.edge_axis <= ax;
    do @(posedge clk); while (!edge_in.ready);
  endtask

  // Wait until every predicted result has come back
  task automatic settle();
    do @(posedge clk); while (pending != 0);
  endtask

  // Write all three size registers while the pipe is empty
  task automatic set_dims(input int dx, input int dy, input int dz);
    edge_in.valid <= 1'b0;
    settle();
    cfg_write <= 1'b1;
    cfg_index <= REG_DIM_X;
    cfg_data  <= DIM_W'(dx);
    @(posedge clk);
    cfg_index <= REG_DIM_Y;
    cfg_data  <= DIM_W'(dy);
    @(posedge clk);
    cfg_index <= REG_DIM_Z;
    cfg_data  <= DIM_W'(dz);
    @(posedge clk);
    cfg_write <= 1'b0;
    span_x = (dx > MAX_DIM) ? MAX_DIM : dx;
    span_y = (dy > MAX_DIM) ? MAX_DIM : dy;
    span_z = (dz > MAX_DIM) ? MAX_DIM : dz;
  endtask

  initial begin
    logic [AXIS_W-1:0] ax;
    int                dims[7][3];
    dims = '{'{2, 2, 2}, '{64, 64, 64}, '{127, 100, 65}, '{0, 3, 4},
             '{1, 1, 9}, '{3, 64, 1}, '{7, 5, 6}};

    rst                   <= 1'b1;
    cfg_write             <= 1'b0;
    cfg_index             <= REG_DIM_X;
    cfg_data              <= '0;
    edge_in.valid         <= 1'b0;
    edge_in.coord_x       <= '0;
    edge_in.coord_y       <= '0;
    edge_in.coord_z       <= '0;
    edge_in.edge_axis     <= AXIS_X;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: corners of the full-size grid, every axis code
    send_edge(0, 0, 0, AXIS_X);
    send_edge(0, 0, 0, AXIS_Y);
    send_edge(0, 0, 0, AXIS_Z);
    send_edge(0, 0, 0, AXIS_NONE);
    send_edge(63, 63, 63, AXIS_X);
    send_edge(63, 63, 63, AXIS_Y);
    send_edge(63, 63, 63, AXIS_Z);
    send_edge(63, 63, 63, AXIS_NONE);
    // last edges before the far faces, where faces dangle
    send_edge(62, 63, 63, AXIS_X);
    send_edge(63, 62, 63, AXIS_Y);
    send_edge(63, 63, 62, AXIS_Z);
    send_edge(1, 1, 1, AXIS_X);
    send_edge(1, 1, 1, AXIS_Y);
    send_edge(1, 1, 1, AXIS_Z);
    send_edge(0, 63, 0, AXIS_X);

    // Directed on a small grid: start point off the grid, end off the grid, edges inside it
    set_dims(5, 4, 3);
    send_edge(5, 0, 0, AXIS_Y);
    send_edge(0, 0, 3, AXIS_X);
    send_edge(4, 3, 2, AXIS_X);
    send_edge(3, 2, 1, AXIS_Z);
    send_edge(0, 3, 0, AXIS_X);

    // Random phases: fixed sizes first (extremes, saturation, degenerate), then random
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p < 7)
        set_dims(dims[p][0], dims[p][1], dims[p][2]);
      else
        set_dims(pick_dim(), pick_dim(), pick_dim());
      steady = (p % 4 == 3);
      for (int n = 0; n < PHASE_EDGES; n++) begin
        ax = ($urandom_range(0, 99) < 5) ? AXIS_NONE : AXIS_W'($urandom_range(0, 2));
        send_edge(pick_coord(span_x), pick_coord(span_y), pick_coord(span_z), ax);
      end
      steady = 1'b0;
    end

    edge_in.valid <= 1'b0;
    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/gei_pkg.sv
sv/gei_if.sv
sv/gei_cfg.sv
sv/gei_pipe.sv
sv/grid_edge_incidence_generator_top.sv
sv/gei_checker.sv
sim/grid_edge_incidence_checker.sv
sim/grid_edge_incidence_generator_top_tb.sv
